@@ rtl/class_file_structure_parser_macros.svh @@
// Assertion macros used by the checker file.
`ifndef CLASS_FILE_STRUCTURE_PARSER_MACROS_SVH
`define CLASS_FILE_STRUCTURE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfsp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfsp assertion failed");

`endif

@@ rtl/cfsp_pkg.sv @@
`default_nettype none
package cfsp_pkg;

  localparam logic [4:0] SEC_MAGIC     = 5'd0;
  localparam logic [4:0] SEC_MINOR     = 5'd1;
  localparam logic [4:0] SEC_MAJOR     = 5'd2;
  localparam logic [4:0] SEC_POOLCNT   = 5'd3;
  localparam logic [4:0] SEC_TAG       = 5'd4;
  localparam logic [4:0] SEC_BODY      = 5'd5;
  localparam logic [4:0] SEC_ACCESS    = 5'd6;
  localparam logic [4:0] SEC_THIS      = 5'd7;
  localparam logic [4:0] SEC_SUPER     = 5'd8;
  localparam logic [4:0] SEC_IFCNT     = 5'd9;
  localparam logic [4:0] SEC_IFIDX     = 5'd10;
  localparam logic [4:0] SEC_FIELDCNT  = 5'd11;
  localparam logic [4:0] SEC_MEMBER    = 5'd12;
  localparam logic [4:0] SEC_ATTRCNT   = 5'd13;
  localparam logic [4:0] SEC_ATTRNAME  = 5'd14;
  localparam logic [4:0] SEC_ATTRLEN   = 5'd15;
  localparam logic [4:0] SEC_ATTRBODY  = 5'd16;
  localparam logic [4:0] SEC_METHCNT   = 5'd17;
  localparam logic [4:0] SEC_DEAD      = 5'd18;
  localparam logic [4:0] SEC_CLASSATTR = 5'd19;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_TAG       = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  localparam logic [31:0] CLASS_MAGIC  = 32'hCAFEBABE;
  localparam logic [3:0]  MIN_LENGTH   = 4'd10;

  localparam logic [7:0] TAG_UTF8      = 8'd1;
  localparam logic [7:0] TAG_LONG      = 8'd5;
  localparam logic [7:0] TAG_DOUBLE    = 8'd6;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
    logic [3:0] body_size;
    logic       wide;
    logic       utf8;
  } cfsp_entry_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [4:0]  section;
    logic        field_end;
    logic [15:0] pool_slot;
    logic [2:0]  error_code;
    logic        file_done;
  } cfsp_result_t;

  function automatic logic [3:0] cfsp_body_size(input logic [7:0] tag);
    logic [3:0] size;
    case (tag)
      8'd1, 8'd7, 8'd8, 8'd16, 8'd19, 8'd20:               size = 4'd2;
      8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: size = 4'd4;
      8'd5, 8'd6:                                          size = 4'd8;
      8'd15:                                               size = 4'd3;
      default:                                             size = 4'd0;
    endcase
    return size;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cfsp_if.sv @@
`default_nettype none
interface cfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_file;

  modport source (output valid, output byte_value, output end_of_file, input ready);
  modport sink (input valid, input byte_value, input end_of_file, output ready);
endinterface

interface cfsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [4:0]  section;
  logic        field_end;
  logic [15:0] pool_slot;
  logic [2:0]  error_code;
  logic        file_done;

  modport source (output valid, output data_byte, output section, output field_end,
                  output pool_slot, output error_code, output file_done, input ready);
  modport sink (input valid, input data_byte, input section, input field_end,
                input pool_slot, input error_code, input file_done, output ready);
endinterface
`default_nettype wire

@@ rtl/class_file_structure_parser.sv @@
// Streaming Java class file labeler. Each input beat carries one byte of a class
// file and a flag on its last byte; each output beat returns that byte with its
// structural section, a field-end mark, the constant pool slot, the latched
// error code and the end-of-file mark. The block sustains one byte per clock
// while the output is ready: the parser state machine in the back end updates
// once per byte, and a two-entry queue plus an output register let either side
// stall independently. State returns to reset after the last byte of each
// file, so files may follow back to back.
`default_nettype none
module class_file_structure_parser (
  input  logic       clk,
  input  logic       rst_n,
  cfsp_in_if.sink    in_ch,
  cfsp_out_if.source out_ch
);
  import cfsp_pkg::*;

  cfsp_entry_t  push_entry;
  cfsp_entry_t  head;
  cfsp_result_t result;
  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_valid;
  logic         out_valid;

  cfsp_front u_front (
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.byte_value),
    .in_eof   (in_ch.end_of_file),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .push     (push),
    .entry    (push_entry)
  );

  cfsp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head)
  );

  cfsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .result    (result)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.data_byte  = result.data_byte;
  assign out_ch.section    = result.section;
  assign out_ch.field_end  = result.field_end;
  assign out_ch.pool_slot  = result.pool_slot;
  assign out_ch.error_code = result.error_code;
  assign out_ch.file_done  = result.file_done;
endmodule
`default_nettype wire

@@ rtl/cfsp_front.sv @@
`default_nettype none
module cfsp_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_eof,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 push,
  output cfsp_pkg::cfsp_entry_t entry
);
  import cfsp_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.byte_value  = in_byte;
    entry.end_of_file = in_eof;
    entry.body_size   = cfsp_body_size(in_byte);
    entry.wide        = (in_byte == TAG_LONG) || (in_byte == TAG_DOUBLE);
    entry.utf8        = (in_byte == TAG_UTF8);
  end
endmodule
`default_nettype wire

@@ rtl/cfsp_fifo.sv @@
`default_nettype none
module cfsp_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cfsp_pkg::cfsp_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  q_valid,
  output cfsp_pkg::cfsp_entry_t head
);
  import cfsp_pkg::*;

  cfsp_entry_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/cfsp_back.sv @@
`default_nettype none
module cfsp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  cfsp_pkg::cfsp_entry_t  q_entry,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cfsp_pkg::cfsp_result_t result
);
  import cfsp_pkg::*;

  logic [4:0]   phase_r, phase_nxt;
  logic [2:0]   bif_r, bif_nxt;
  logic [3:0]   seen_r, seen_nxt;
  logic [31:0]  magic_r, magic_nxt;
  logic [15:0]  pool_rem_r, pool_rem_nxt;
  logic [15:0]  slot_r, slot_nxt;
  logic [15:0]  body_rem_r, body_rem_nxt;
  logic [7:0]   hold_r, hold_nxt;
  logic [15:0]  list_rem_r, list_rem_nxt;
  logic [15:0]  attr_rem_r, attr_rem_nxt;
  logic [31:0]  attr_left_r, attr_left_nxt;
  logic         in_meth_r, in_meth_nxt;
  logic [2:0]   err_r, err_nxt;
  logic         out_valid_r;
  cfsp_result_t result_r, result_nxt;

  logic [7:0]   b;
  logic         eof;
  logic [15:0]  word;
  logic [15:0]  list_dec;
  logic [15:0]  attr_dec;
  logic [15:0]  body_dec;
  logic [31:0]  left_dec;
  logic [15:0]  pool_dec;
  logic [4:0]   member_phase;
  logic [4:0]   sec;
  logic         fe;
  logic [15:0]  slot_out;
  logic [2:0]   bif_inc;
  logic         body_done;
  logic         body_two;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  assign b        = q_entry.byte_value;
  assign eof      = q_entry.end_of_file;
  assign word     = {hold_r, b};
  assign list_dec = (list_rem_r != 16'd0) ? list_rem_r - 16'd1 : 16'd0;
  assign attr_dec = (attr_rem_r != 16'd0) ? attr_rem_r - 16'd1 : 16'd0;
  assign body_dec = (body_rem_r != 16'd0) ? body_rem_r - 16'd1 : 16'd0;
  assign left_dec = (attr_left_r != 32'd0) ? attr_left_r - 32'd1 : 32'd0;
  assign pool_dec = q_entry.wide ? 16'd2 : 16'd1;
  assign bif_inc  = bif_r + 3'd1;
  assign member_phase = (list_dec != 16'd0) ? SEC_MEMBER :
                        (in_meth_r ? SEC_CLASSATTR : SEC_METHCNT);

  always_comb begin
    phase_nxt     = phase_r;
    bif_nxt       = bif_r;
    seen_nxt      = (seen_r < MIN_LENGTH) ? seen_r + 4'd1 : seen_r;
    magic_nxt     = magic_r;
    pool_rem_nxt  = pool_rem_r;
    slot_nxt      = slot_r;
    body_rem_nxt  = body_rem_r;
    hold_nxt      = hold_r;
    list_rem_nxt  = list_rem_r;
    attr_rem_nxt  = attr_rem_r;
    attr_left_nxt = attr_left_r;
    in_meth_nxt   = in_meth_r;
    err_nxt       = err_r;
    sec           = phase_r;
    fe            = 1'b0;
    slot_out      = 16'd0;
    body_done     = 1'b0;
    body_two      = 1'b0;

    case (phase_r)
      SEC_MAGIC: begin
        magic_nxt = {magic_r[23:0], b};
        bif_nxt   = bif_inc;
        if (bif_r >= 3'd3) begin
          bif_nxt = 3'd0;
          fe      = 1'b1;
          if ({magic_r[23:0], b} != CLASS_MAGIC) begin
            err_nxt   = ERR_MAGIC;
            phase_nxt = SEC_DEAD;
          end else begin
            phase_nxt = SEC_MINOR;
          end
        end
      end
      SEC_MINOR, SEC_MAJOR, SEC_ACCESS, SEC_THIS, SEC_SUPER: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt   = 3'd0;
          fe        = 1'b1;
          phase_nxt = phase_r + 5'd1;
        end
      end
      SEC_POOLCNT: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt      = 3'd0;
          fe           = 1'b1;
          pool_rem_nxt = (word > 16'd1) ? word - 16'd1 : 16'd0;
          slot_nxt     = 16'd1;
          phase_nxt    = (word > 16'd1) ? SEC_TAG : SEC_ACCESS;
        end
      end
      SEC_TAG: begin
        slot_out = slot_r;
        fe       = 1'b1;
        if (q_entry.body_size == 4'd0) begin
          err_nxt   = ERR_TAG;
          phase_nxt = SEC_DEAD;
        end else begin
          pool_rem_nxt = (pool_rem_r > pool_dec) ? pool_rem_r - pool_dec : 16'd0;
          if (q_entry.utf8) begin
            bif_nxt = 3'd1;
          end else if (q_entry.wide) begin
            bif_nxt = 3'd4;
          end else begin
            bif_nxt = 3'd0;
          end
          body_rem_nxt = {12'd0, q_entry.body_size};
          phase_nxt    = SEC_BODY;
        end
      end
      SEC_BODY: begin
        slot_out = slot_r;
        if (bif_r == 3'd1) begin
          hold_nxt = b;
          bif_nxt  = 3'd2;
        end else if (bif_r == 3'd2) begin
          body_rem_nxt = word;
          bif_nxt      = 3'd0;
          body_done    = (word == 16'd0);
        end else begin
          body_rem_nxt = body_dec;
          body_done    = (body_dec == 16'd0);
          body_two     = (bif_r == 3'd4);
        end
        if (body_done) begin
          fe        = 1'b1;
          slot_nxt  = slot_r + (body_two ? 16'd2 : 16'd1);
          bif_nxt   = 3'd0;
          phase_nxt = (pool_rem_r != 16'd0) ? SEC_TAG : SEC_ACCESS;
        end
      end
      SEC_IFCNT: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt      = 3'd0;
          fe           = 1'b1;
          list_rem_nxt = word;
          phase_nxt    = (word != 16'd0) ? SEC_IFIDX : SEC_FIELDCNT;
        end
      end
      SEC_IFIDX: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt      = 3'd0;
          fe           = 1'b1;
          list_rem_nxt = list_dec;
          if (list_dec == 16'd0) begin
            phase_nxt = SEC_FIELDCNT;
          end
        end
      end
      SEC_FIELDCNT, SEC_METHCNT: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt      = 3'd0;
          fe           = 1'b1;
          list_rem_nxt = word;
          in_meth_nxt  = (phase_r == SEC_METHCNT);
          if (word != 16'd0) begin
            phase_nxt = SEC_MEMBER;
          end else begin
            phase_nxt = (phase_r == SEC_METHCNT) ? SEC_CLASSATTR : SEC_METHCNT;
          end
        end
      end
      SEC_MEMBER: begin
        bif_nxt = bif_inc;
        fe      = !bif_inc[0];
        if (bif_inc >= 3'd6) begin
          bif_nxt   = 3'd0;
          phase_nxt = SEC_ATTRCNT;
        end
      end
      SEC_ATTRCNT: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt      = 3'd0;
          fe           = 1'b1;
          attr_rem_nxt = word;
          if (word != 16'd0) begin
            phase_nxt = SEC_ATTRNAME;
          end else begin
            list_rem_nxt = list_dec;
            phase_nxt    = member_phase;
          end
        end
      end
      SEC_ATTRNAME: begin
        if (bif_r == 3'd0) begin
          hold_nxt = b;
          bif_nxt  = 3'd1;
        end else begin
          bif_nxt   = 3'd0;
          fe        = 1'b1;
          phase_nxt = SEC_ATTRLEN;
        end
      end
      SEC_ATTRLEN: begin
        attr_left_nxt = {attr_left_r[23:0], b};
        bif_nxt       = bif_inc;
        if (bif_r >= 3'd3) begin
          bif_nxt = 3'd0;
          fe      = 1'b1;
          if ({attr_left_r[23:0], b} != 32'd0) begin
            phase_nxt = SEC_ATTRBODY;
          end else begin
            attr_rem_nxt = attr_dec;
            if (attr_dec != 16'd0) begin
              phase_nxt = SEC_ATTRNAME;
            end else begin
              list_rem_nxt = list_dec;
              phase_nxt    = member_phase;
            end
          end
        end
      end
      SEC_ATTRBODY: begin
        attr_left_nxt = left_dec;
        if (left_dec == 32'd0) begin
          fe           = 1'b1;
          attr_rem_nxt = attr_dec;
          if (attr_dec != 16'd0) begin
            phase_nxt = SEC_ATTRNAME;
          end else begin
            list_rem_nxt = list_dec;
            phase_nxt    = member_phase;
          end
        end
      end
      SEC_CLASSATTR: begin
        fe = eof;
      end
      default: begin
        sec       = SEC_DEAD;
        phase_nxt = SEC_DEAD;
      end
    endcase

    if (eof) begin
      if (seen_nxt < MIN_LENGTH) begin
        err_nxt = ERR_SHORT;
      end else if (err_nxt == ERR_NONE && phase_nxt != SEC_CLASSATTR) begin
        err_nxt = ERR_TRUNC;
      end
    end

    result_nxt.data_byte  = b;
    result_nxt.section    = sec;
    result_nxt.field_end  = fe;
    result_nxt.pool_slot  = slot_out;
    result_nxt.error_code = err_nxt;
    result_nxt.file_done  = eof;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (pop && eof)) begin
      phase_r     <= SEC_MAGIC;
      bif_r       <= 3'd0;
      seen_r      <= 4'd0;
      magic_r     <= 32'd0;
      pool_rem_r  <= 16'd0;
      slot_r      <= 16'd0;
      body_rem_r  <= 16'd0;
      hold_r      <= 8'd0;
      list_rem_r  <= 16'd0;
      attr_rem_r  <= 16'd0;
      attr_left_r <= 32'd0;
      in_meth_r   <= 1'b0;
      err_r       <= ERR_NONE;
    end else if (pop) begin
      phase_r     <= phase_nxt;
      bif_r       <= bif_nxt;
      seen_r      <= seen_nxt;
      magic_r     <= magic_nxt;
      pool_rem_r  <= pool_rem_nxt;
      slot_r      <= slot_nxt;
      body_rem_r  <= body_rem_nxt;
      hold_r      <= hold_nxt;
      list_rem_r  <= list_rem_nxt;
      attr_rem_r  <= attr_rem_nxt;
      attr_left_r <= attr_left_nxt;
      in_meth_r   <= in_meth_nxt;
      err_r       <= err_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/cfsp_checker.sv @@
`default_nettype none
`include "class_file_structure_parser_macros.svh"
module cfsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_data_byte,
  input logic [4:0]  out_section,
  input logic        out_field_end,
  input logic [15:0] out_pool_slot,
  input logic [2:0]  out_error_code,
  input logic        out_file_done
);
  import cfsp_pkg::*;

  // A stalled output beat keeps its whole payload.
  `CFSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_data_byte, out_section, out_field_end, out_pool_slot, out_error_code, out_file_done}))
  // Bytes after an error never close a field.
  `CFSP_ASSERT_IMPLY(a_dead_no_end, clk, rst_n, out_valid && out_section == SEC_DEAD, !out_field_end)
  // Only pool tag and body bytes carry a slot number.
  `CFSP_ASSERT_IMPLY(a_slot_in_pool, clk, rst_n, out_valid && out_pool_slot != 16'd0, out_section == SEC_TAG || out_section == SEC_BODY)
  // A clean class attribute byte at end of file closes the field and reports no error.
  `CFSP_ASSERT_IMPLY(a_classattr_end, clk, rst_n, out_valid && out_file_done && out_section == SEC_CLASSATTR && out_error_code != ERR_SHORT, out_field_end && out_error_code == ERR_NONE)
endmodule

bind class_file_structure_parser cfsp_checker u_cfsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data_byte  (out_ch.data_byte),
  .out_section    (out_ch.section),
  .out_field_end  (out_ch.field_end),
  .out_pool_slot  (out_ch.pool_slot),
  .out_error_code (out_ch.error_code),
  .out_file_done  (out_ch.file_done)
);
`default_nettype wire
